/* sv/pec_pkg.sv */
// Shared types, register map and gain-curve tables for the peak envelope compressor.
// No dependencies; used by pec_cfg, pec_core and peak_envelope_compressor.
package pec_pkg;

  // configuration port address width and register indexes
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_SLOPE     = 3'd1;
  localparam logic [2:0] REG_ATTACK    = 3'd2;
  localparam logic [2:0] REG_RELEASE   = 3'd3;
  localparam logic [2:0] REG_MAKEUP    = 3'd4;

  // command from the channel side to the sequencer
  typedef struct packed {
    logic start;
    logic block_start;
    logic take;
  } pec_cmd_t;

  // status from the sequencer back to the channel side
  typedef struct packed {
    logic idle;
    logic done;
  } pec_stat_t;

  // log2(1 + i/16) in Q16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // 2^(i/16) in Q16
  function automatic logic [17:0] exp2_tab(input logic [4:0] i);
    logic [17:0] v;
    case (i)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

/* sv/pec_mult.sv */
// Shared unsigned multiplier with a registered product.
// No dependencies; instantiated by pec_core.
module pec_mult #(
  parameter int MW = 24
) (
  input  logic            clk,
  input  logic [MW-1:0]   a,
  input  logic [MW-1:0]   b,
  output logic [2*MW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* sv/pec_cfg.sv */
// APB-style configuration registers of the peak envelope compressor.
// Depends on pec_pkg for the register indexes.
module pec_cfg #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pec_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [SAMPLE_WIDTH-2:0]       threshold_level,
  output logic [COEF_WIDTH-1:0]         ratio_slope,
  output logic [COEF_WIDTH-1:0]         attack_coef,
  output logic [COEF_WIDTH-1:0]         release_coef,
  output logic [SAMPLE_WIDTH-1:0]       makeup_gain
);

  localparam int W = SAMPLE_WIDTH;
  localparam int F = W - 1;
  localparam int C = COEF_WIDTH;
  localparam logic [C+15:0] ATTACK_WIDE  = (C+16)'(1638) << C;
  localparam logic [C+15:0] RELEASE_WIDE = (C+16)'(131) << C;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= {F{1'b1}};
      ratio_slope     <= '0;
      attack_coef     <= ATTACK_WIDE[C+15:16];
      release_coef    <= RELEASE_WIDE[C+15:16];
      makeup_gain     <= {2'b01, {(W-2){1'b0}}};
    end else if (wr) begin
      unique case (idx)
        pec_pkg::REG_THRESHOLD: threshold_level <= pwdata[F-1:0];
        pec_pkg::REG_SLOPE:     ratio_slope     <= pwdata[C-1:0];
        pec_pkg::REG_ATTACK:    attack_coef     <= pwdata[C-1:0];
        pec_pkg::REG_RELEASE:   release_coef    <= pwdata[C-1:0];
        pec_pkg::REG_MAKEUP:    makeup_gain     <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pec_pkg::REG_THRESHOLD: prdata[F-1:0] = threshold_level;
      pec_pkg::REG_SLOPE:     prdata[C-1:0] = ratio_slope;
      pec_pkg::REG_ATTACK:    prdata[C-1:0] = attack_coef;
      pec_pkg::REG_RELEASE:   prdata[C-1:0] = release_coef;
      pec_pkg::REG_MAKEUP:    prdata[W-1:0] = makeup_gain;
      default: prdata = '0;
    endcase
  end

endmodule

/* sv/pec_core.sv */
// Sequencer and datapath of the compressor: envelope, log2/exp2 gain curve,
// gain smoothing and output scaling, all on one shared multiplier.
// Depends on pec_pkg and pec_mult.
module pec_core #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pec_pkg::pec_cmd_t        cmd,
  output pec_pkg::pec_stat_t       stat,
  input  logic [SAMPLE_WIDTH-1:0]  sample_in,
  output logic [SAMPLE_WIDTH-1:0]  sample_out,
  input  logic [SAMPLE_WIDTH-2:0]  threshold_level,
  input  logic [COEF_WIDTH-1:0]    ratio_slope,
  input  logic [COEF_WIDTH-1:0]    attack_coef,
  input  logic [COEF_WIDTH-1:0]    release_coef,
  input  logic [SAMPLE_WIDTH-1:0]  makeup_gain
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int F  = W - 1;
  localparam int C  = COEF_WIDTH;
  localparam int PW = $clog2(W);
  localparam int NW = $clog2(W + 1);
  localparam int LW = NW + 16;
  localparam int MW0 = (W > LW) ? W : LW;
  localparam int MW = (MW0 > C) ? MW0 : C;
  localparam int PRW = 2 * MW;
  localparam int TAB_SHIFT = F - 4;
  localparam logic [C-1:0] SMOOTH = C'(((2 << C) + 12) / 25);
  localparam logic [W-1:0] UNITY = {1'b1, {F{1'b0}}};
  localparam logic [W-1:0] MAX_POS = {1'b0, {F{1'b1}}};
  localparam logic [PRW:0] HALF_C = (PRW+1)'(1) << (C - 1);
  localparam logic [PRW:0] HALF_F = (PRW+1)'(1) << (F - 1);
  localparam logic [PRW:0] HALF_F2 = (PRW+1)'(1) << (F - 2);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ENV_MUL  = 5'd1;
  localparam logic [4:0] S_ENV_UPD  = 5'd2;
  localparam logic [4:0] S_TGT_CHK  = 5'd3;
  localparam logic [4:0] S_LOG_P    = 5'd4;
  localparam logic [4:0] S_LOG_MUL  = 5'd5;
  localparam logic [4:0] S_LOG_ACC  = 5'd6;
  localparam logic [4:0] S_SLP_MUL  = 5'd7;
  localparam logic [4:0] S_EXP_MUL  = 5'd8;
  localparam logic [4:0] S_EXP_ACC  = 5'd9;
  localparam logic [4:0] S_GAIN_MUL = 5'd10;
  localparam logic [4:0] S_GAIN_UPD = 5'd11;
  localparam logic [4:0] S_OUT1_MUL = 5'd12;
  localparam logic [4:0] S_OUT1_RND = 5'd13;
  localparam logic [4:0] S_OUT2_MUL = 5'd14;
  localparam logic [4:0] S_OUT2_RND = 5'd15;
  localparam logic [4:0] S_DONE     = 5'd16;

  logic [4:0]      state;
  logic [W-1:0]    env;
  logic [W-1:0]    gain;
  logic [W-1:0]    mag;
  logic            neg;
  logic            up;
  logic            pass2;
  logic [W-1:0]    lval;
  logic [PW-1:0]   p;
  logic [LW-1:0]   lbase;
  logic [LW-1:0]   la;
  logic [LW-1:0]   lb;
  logic [W-1:0]    tgt;
  logic [NW-1:0]   n;
  logic [17:0]     ebase;
  logic [W-1:0]    mag1;
  logic [W-1:0]    res;

  logic [MW-1:0]   ma;
  logic [MW-1:0]   mb;
  logic [PRW-1:0]  prod;

  logic [PW-1:0]   p_calc;
  logic [W-1:0]    norm;
  logic [3:0]      lidx;
  logic [16:0]     ldiff;
  logic [LW-1:0]   lres;
  logic [LW-1:0]   d;
  logic [LW-1:0]   e_val;
  logic [16:0]     g;
  logic [4:0]      eidx;
  logic [17:0]     ediff;
  logic [17:0]     val;
  logic [NW:0]     sh_e;
  logic [F+17:0]   tshift;
  logic [PRW:0]    rsum_c;
  logic [PRW:0]    rsum_f;
  logic [PRW:0]    rsum_f2;
  logic [W-1:0]    step;
  logic [W+1:0]    mag2;
  logic [W-1:0]    mag_in;
  logic            env_up;
  logic            gain_up;

  pec_mult #(.MW(MW)) u_mult (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .prod (prod)
  );

  always_comb begin
    p_calc = '0;
    for (int i = 0; i < W; i++) begin
      if (lval[i]) p_calc = PW'(i);
    end
    norm   = lval << (PW'(F) - p);
    lidx   = norm[F-1 -: 4];
    ldiff  = pec_pkg::log2_tab({1'b0, lidx} + 5'd1) - pec_pkg::log2_tab({1'b0, lidx});
    lres   = lbase + LW'(prod[TAB_SHIFT +: 17]);
    d      = (la > lb) ? (la - lb) : '0;
    e_val  = prod[C +: LW];
    g      = 17'd65536 - {1'b0, e_val[15:0]};
    eidx   = g[16:12];
    ediff  = pec_pkg::exp2_tab(eidx + 5'd1) - pec_pkg::exp2_tab(eidx);
    val    = ebase + prod[29:12];
    sh_e   = (NW+1)'(17) + {1'b0, n};
    tshift = {val, {F{1'b0}}} >> sh_e;
    rsum_c  = {1'b0, prod} + HALF_C;
    rsum_f  = {1'b0, prod} + HALF_F;
    rsum_f2 = {1'b0, prod} + HALF_F2;
    step    = rsum_c[C +: W];
    mag2    = rsum_f2[(F-1) +: (W+2)];
    mag_in  = sample_in[W-1] ? (~sample_in + W'(1)) : sample_in;
    env_up  = mag > env;
    gain_up = tgt >= gain;

    // operand select for the shared multiplier
    ma = '0;
    mb = '0;
    unique case (state)
      S_ENV_MUL: begin
        ma = MW'(env_up ? (mag - env) : (env - mag));
        mb = MW'(env_up ? attack_coef : release_coef);
      end
      S_LOG_MUL: begin
        ma = MW'(norm[TAB_SHIFT-1:0]);
        mb = MW'(ldiff);
      end
      S_SLP_MUL: begin
        ma = MW'(d);
        mb = MW'(ratio_slope);
      end
      S_EXP_MUL: begin
        ma = MW'(g[11:0]);
        mb = (eidx[4]) ? '0 : MW'(ediff);
      end
      S_GAIN_MUL: begin
        ma = MW'(gain_up ? (tgt - gain) : (gain - tgt));
        mb = MW'(SMOOTH);
      end
      S_OUT1_MUL: begin
        ma = MW'(mag);
        mb = MW'(gain);
      end
      S_OUT2_MUL: begin
        ma = MW'(mag1);
        mb = MW'(makeup_gain);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      env   <= '0;
      gain  <= UNITY;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            mag <= mag_in;
            neg <= sample_in[W-1];
            if (cmd.block_start) begin
              env  <= '0;
              gain <= UNITY;
            end
            state <= S_ENV_MUL;
          end
        end
        S_ENV_MUL: begin
          up    <= env_up;
          state <= S_ENV_UPD;
        end
        S_ENV_UPD: begin
          env   <= up ? (env + step) : (env - step);
          state <= S_TGT_CHK;
        end
        S_TGT_CHK: begin
          if (env <= {1'b0, threshold_level}) begin
            tgt   <= UNITY;
            state <= S_GAIN_MUL;
          end else if (threshold_level == '0) begin
            tgt   <= '0;
            state <= S_GAIN_MUL;
          end else begin
            lval  <= env;
            pass2 <= 1'b0;
            state <= S_LOG_P;
          end
        end
        S_LOG_P: begin
          p     <= p_calc;
          state <= S_LOG_MUL;
        end
        S_LOG_MUL: begin
          lbase <= {p, 16'd0} + LW'(pec_pkg::log2_tab({1'b0, lidx}));
          state <= S_LOG_ACC;
        end
        S_LOG_ACC: begin
          if (!pass2) begin
            la    <= lres;
            lval  <= {1'b0, threshold_level};
            pass2 <= 1'b1;
            state <= S_LOG_P;
          end else begin
            lb    <= lres;
            state <= S_SLP_MUL;
          end
        end
        S_SLP_MUL: begin
          state <= S_EXP_MUL;
        end
        S_EXP_MUL: begin
          n     <= e_val[LW-1:16];
          ebase <= pec_pkg::exp2_tab(eidx);
          state <= S_EXP_ACC;
        end
        S_EXP_ACC: begin
          tgt   <= tshift[W-1:0];
          state <= S_GAIN_MUL;
        end
        S_GAIN_MUL: begin
          up    <= gain_up;
          state <= S_GAIN_UPD;
        end
        S_GAIN_UPD: begin
          gain  <= up ? (gain + step) : (gain - step);
          state <= S_OUT1_MUL;
        end
        S_OUT1_MUL: begin
          state <= S_OUT1_RND;
        end
        S_OUT1_RND: begin
          mag1  <= rsum_f[F +: W];
          state <= S_OUT2_MUL;
        end
        S_OUT2_MUL: begin
          state <= S_OUT2_RND;
        end
        S_OUT2_RND: begin
          if (neg) begin
            res <= (mag2 > {2'b00, UNITY}) ? UNITY : (~mag2[W-1:0] + W'(1));
          end else begin
            res <= (mag2 > {2'b00, MAX_POS}) ? MAX_POS : mag2[W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle  = (state == S_IDLE);
  assign stat.done  = (state == S_DONE);
  assign sample_out = res;

endmodule

/* sv/peak_envelope_compressor.sv */
// Top level of the peak envelope compressor: stream channels, output register,
// configuration port. Depends on pec_pkg, pec_cfg and pec_core (pec_mult below it).
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  s_tdata: sample_in; s_tuser: block_start
//   m_*       out        m_tvalid/m_tready  m_tdata: sample_out
//   apb       in         psel/penable       paddr, pwdata, prdata (5 registers at 4*i)
//
// The sequencer drives the single shared multiplier four times per item when the
// envelope is at or below the threshold (or the threshold is zero) and eight times
// otherwise (envelope, gain and two output scalings, plus two log2 interpolations,
// slope and exp2 on the long path). s_tready is high only while the sequencer is
// idle. The result sits in an output register, so the next item is taken while it
// waits; a stalled output holds the sequencer in its final step.
// Reset (rst, synchronous) clears the envelope to zero, the gain to unity and
// loads the register defaults.
module peak_envelope_compressor #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample_in [SAMPLE_WIDTH-1:0], zero fill to whole bytes
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
  // block_start [0]
  input  logic                                s_tuser,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // sample_out [SAMPLE_WIDTH-1:0], zero fill to whole bytes
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pec_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int C  = COEF_WIDTH;
  localparam int DW = ((W + 7) / 8) * 8;

  logic [W-2:0]        threshold_level;
  logic [C-1:0]        ratio_slope;
  logic [C-1:0]        attack_coef;
  logic [C-1:0]        release_coef;
  logic [W-1:0]        makeup_gain;
  pec_pkg::pec_cmd_t   cmd;
  pec_pkg::pec_stat_t  stat;
  logic [W-1:0]        core_out;
  logic                slot_free;
  logic [W-1:0]        out_data;

  pec_cfg #(
    .SAMPLE_WIDTH (W),
    .COEF_WIDTH   (C)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .threshold_level (threshold_level),
    .ratio_slope     (ratio_slope),
    .attack_coef     (attack_coef),
    .release_coef    (release_coef),
    .makeup_gain     (makeup_gain)
  );

  // accept only while the sequencer is idle
  assign s_tready = stat.idle;

  // output slot is free when empty or being drained this cycle
  assign slot_free = !m_tvalid || m_tready;

  assign cmd.start       = s_tvalid && stat.idle;
  assign cmd.block_start = s_tuser;
  assign cmd.take        = slot_free;

  pec_core #(
    .SAMPLE_WIDTH (W),
    .COEF_WIDTH   (C)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .sample_in       (s_tdata[W-1:0]),
    .sample_out      (core_out),
    .threshold_level (threshold_level),
    .ratio_slope     (ratio_slope),
    .attack_coef     (attack_coef),
    .release_coef    (release_coef),
    .makeup_gain     (makeup_gain)
  );

  // output register: load the finished item, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.done && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && slot_free) begin
      out_data <= core_out;
    end
  end

  assign m_tdata = DW'(out_data);

endmodule
